// ----- rtl/priority_task_queue_assert.svh -----
// Assertion macros for the priority task queue.
`ifndef PRIORITY_TASK_QUEUE_ASSERT_SVH
`define PRIORITY_TASK_QUEUE_ASSERT_SVH

// same-cycle implication
`define PTQ_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("priority_task_queue: check failed");

// next-cycle implication
`define PTQ_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("priority_task_queue: check failed");

`endif

// ----- rtl/ptq_pkg.sv -----
// Shared types and constants of the priority task queue.
`default_nettype none
package ptq_pkg;

    localparam int PRIO_W     = 8;
    localparam int TIME_W     = 31;
    localparam int ID_W       = 16;
    localparam int STATUS_W   = 2;
    localparam int TOTAL_W    = 7;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 64;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_POP    = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] exec_time;
        logic [PRIO_W-1:0] prio;
    } t_task;

    typedef struct packed {
        logic  is_pop;
        t_task tsk;
    } t_req;

    typedef struct packed {
        logic [TOTAL_W-1:0]  total;
        t_task               tsk;
        logic [STATUS_W-1:0] status;
    } t_result;

endpackage
`default_nettype wire

// ----- rtl/ptq_front.sv -----
// Request front end: accept, decode and queue incoming items.
`default_nettype none
module ptq_front
    import ptq_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_tvalid,
    output logic                      o_tready,
    input  wire logic [IN_DATA_W-1:0] i_tdata,
    input  wire logic                 i_tuser,
    output logic                      o_req_valid,
    output t_req                      o_req,
    input  wire logic                 i_req_ready
);

    t_req       r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_fill, n_fill;
    t_req       w_dec;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_dec.is_pop        = (i_tuser == REQ_POP);
        w_dec.tsk.prio      = i_tdata[PRIO_W-1:0];
        w_dec.tsk.exec_time = i_tdata[PRIO_W+TIME_W-1:PRIO_W];
        w_dec.tsk.id        = i_tdata[PRIO_W+TIME_W+ID_W-1:PRIO_W+TIME_W];
    end

    assign o_tready    = (r_fill != 2'd2);
    assign o_req_valid = (r_fill != 2'd0);
    assign o_req       = r_mem[r_rd_ptr];
    assign w_push      = i_tvalid && o_tready;
    assign w_pop       = o_req_valid && i_req_ready;

    always_comb begin
        n_wr_ptr = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? ~r_rd_ptr : r_rd_ptr;
        n_fill   = r_fill + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_dec;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/ptq_sort_array.sv -----
// Sorted task array: parallel compare-and-shift cells and result register.
`default_nettype none
`include "priority_task_queue_assert.svh"
module ptq_sort_array
    import ptq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    input  wire t_req i_req,
    output logic      o_req_ready,
    output logic      o_out_valid,
    output t_result   o_result,
    input  wire logic i_out_ready
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_task            r_cell [QUEUE_DEPTH];
    t_task            n_cell [QUEUE_DEPTH];
    logic [CW-1:0]    r_count, n_count;
    logic             r_out_valid;
    t_result          r_result, n_result;
    logic [QUEUE_DEPTH-1:0] w_ge;
    logic             w_take;
    logic             w_full;
    logic             w_empty;
    logic             w_write;
    logic [PRIO_W+TIME_W+ID_W-1:0] w_fresh_key;

    assign w_take      = i_req_valid && o_req_ready;
    assign o_req_ready = !r_out_valid || i_out_ready;
    assign w_full      = (r_count == CW'(QUEUE_DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_write     = w_take && (i_req.is_pop ? !w_empty : !w_full);
    assign w_fresh_key = {i_req.tsk.prio, ~i_req.tsk.exec_time, ~i_req.tsk.id};

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic w_beat;
        assign w_beat = (w_fresh_key >
                         {r_cell[i].prio, ~r_cell[i].exec_time, ~r_cell[i].id})
                        && (CW'(i) < r_count);
        assign w_ge[i] = w_beat || (CW'(i) >= r_count);

        always_comb begin
            n_cell[i] = r_cell[i];
            if (i_req.is_pop) begin
                if (i < QUEUE_DEPTH - 1) begin
                    n_cell[i] = r_cell[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                end
            end else if (w_ge[i]) begin
                if (i == 0) begin
                    n_cell[i] = i_req.tsk;
                end else if (!w_ge[(i > 0) ? i - 1 : 0]) begin
                    n_cell[i] = i_req.tsk;
                end else begin
                    n_cell[i] = r_cell[(i > 0) ? i - 1 : 0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_write) begin
                r_cell[i] <= n_cell[i];
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        n_result = '0;
        if (i_req.is_pop) begin
            if (w_empty) begin
                n_result.status = ST_EMPTY;
            end else begin
                n_count         = r_count - CW'(1);
                n_result.status = ST_OK;
                n_result.tsk    = r_cell[0];
            end
        end else begin
            if (w_full) begin
                n_result.status = ST_FULL;
            end else begin
                n_count         = r_count + CW'(1);
                n_result.status = ST_OK;
            end
        end
        n_result.total = TOTAL_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_count <= n_count;
            end
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    `PTQ_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(QUEUE_DEPTH))
    `PTQ_ASSERT_NXT(a_empty_pop, i_clk, i_rst_n,
                    w_take && i_req.is_pop && w_empty,
                    r_out_valid && r_result.status == ST_EMPTY && r_count == '0)
    `PTQ_ASSERT_NXT(a_insert_grows, i_clk, i_rst_n,
                    w_take && !i_req.is_pop && !w_full,
                    r_count == $past(r_count) + CW'(1))

endmodule
`default_nettype wire

// ----- rtl/priority_task_queue.sv -----
// Priority task queue top level: stream ports, request queue and sorted array.
// A result is offered once its request has passed the request queue and the
// output register. Throughput: one request per cycle unless the output stalls;
// each insert or pop is a compare-and-shift across the cell row, one comparator
// per cell. Reset clears the task count, the request queue and the output
// valid flag; cell contents are undefined until written and need no clearing pass.
`default_nettype none
module priority_task_queue
    import ptq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // task_priority [7:0], task_time [38:8], task_id [54:39], zero pad [55]
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // req_type [0]
    input  wire logic                  i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // out_priority [7:0], out_time [38:8], out_id [54:39], entry_total [61:55], pad [63:62]
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,
    // status [1:0]
    output logic [STATUS_W-1:0]        o_m_axis_tuser
);

    logic    w_req_valid;
    logic    w_req_ready;
    t_req    w_req;
    t_result w_result;

    ptq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tvalid    (i_s_axis_tvalid),
        .o_tready    (o_s_axis_tready),
        .i_tdata     (i_s_axis_tdata),
        .i_tuser     (i_s_axis_tuser),
        .o_req_valid (w_req_valid),
        .o_req       (w_req),
        .i_req_ready (w_req_ready)
    );

    ptq_sort_array #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_sort_array (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_req_valid),
        .i_req       (w_req),
        .o_req_ready (w_req_ready),
        .o_out_valid (o_m_axis_tvalid),
        .o_result    (w_result),
        .i_out_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {2'b00, w_result.total, w_result.tsk.id,
                             w_result.tsk.exec_time, w_result.tsk.prio};
    assign o_m_axis_tuser = w_result.status;

endmodule
`default_nettype wire
